// ----- hw/rtl/http_host_request_filter_unit_defines.svh -----
// Assertion macros shared by the filter checker.
// Depends on nothing; include guarded.
`ifndef HTTP_HOST_REQUEST_FILTER_UNIT_DEFINES_SVH
`define HTTP_HOST_REQUEST_FILTER_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define HHF_ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define HHF_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- hw/rtl/hhf_pkg.sv -----
// Package for the HTTP host request filter: types, codes and method table.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
package hhf_pkg;
    localparam int HostLenDef   = 32;
    localparam int MaxFrameDef  = 65535;
    localparam int QueueDepth   = 4;

    typedef enum logic [3:0] {
        PH_ETH, PH_IP, PH_TCP, PH_L1_SKIP, PH_METHOD, PH_L1_REST, PH_L2_SKIP,
        PH_L2_SEP1, PH_L2_TOK1, PH_L2_SEP2, PH_L2_TOK2, PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        V_MATCH = 3'd0, V_NOT_IPV4 = 3'd1, V_NOT_TCP = 3'd2, V_NO_PAYLOAD = 3'd3,
        V_NO_METHOD = 3'd4, V_NO_HOST = 3'd5, V_MISMATCH = 3'd6, V_TRUNC = 3'd7
    } verdict_t;

    localparam logic [2:0] METHOD_NONE = 3'd6;

    typedef enum logic [2:0] {
        CFG_HOST0 = 3'd0, CFG_HOST1 = 3'd1, CFG_HOST2 = 3'd2, CFG_HOST3 = 3'd3,
        CFG_HOST_LEN = 3'd4
    } cfg_idx_t;

    // Classified byte handed from front to back.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       in_range;
        logic       is_crlf;
        logic       is_sep;
    } token_t;

    typedef struct packed {
        logic       block;
        logic [2:0] verdict;
        logic [2:0] method;
    } result_t;

    function automatic logic [7:0] method_char(input logic [2:0] m, input logic [2:0] k);
        logic [55:0] s;
        begin
            unique case (m)
                3'd0: s = {32'h0, "TEG"};
                3'd1: s = {24'h0, "TSOP"};
                3'd2: s = {24'h0, "DAEH"};
                3'd3: s = {32'h0, "TUP"};
                3'd4: s = {8'h0, "ETELED"};
                3'd5: s = "SNOITPO";
                default: s = '0;
            endcase
            method_char = s[k*8 +: 8];
        end
    endfunction

    function automatic logic [2:0] method_len(input logic [2:0] m);
        begin
            unique case (m)
                3'd0, 3'd3: method_len = 3'd3;
                3'd1, 3'd2: method_len = 3'd4;
                3'd4: method_len = 3'd6;
                3'd5: method_len = 3'd7;
                default: method_len = 3'd0;
            endcase
        end
    endfunction
endpackage

// ----- hw/rtl/http_host_request_filter_unit.sv -----
// HTTP host request filter, top level.
// Depends on hhf_pkg, hhf_front, hhf_queue and hhf_back.
//
// Usage: frame bytes enter on the frame channel (frame_byte, frame_last,
// valid/ready), one byte per transaction. On the transaction that carries
// frame_last the block gives one result transaction on the result channel:
// block_frame, verdict and method_found. Other bytes give no result.
// Throughput is one byte per cycle while the result receiver does not stall;
// the back stage's per-byte parse step sets that figure. The result of a
// frame passes through the queue and then the result register; every byte
// still waiting in the queue ahead of it delays it further.
// The host pattern (CFG_HOST0..3, CFG_HOST_LEN) is written through the
// cfg port; the user must write it only while no frame is in flight, which
// the block itself does not enforce. Writes take effect at once.
// Reset clears the parse state, the queue and the pattern registers.
// When the receiver stalls, the result register holds; the back stage then
// stops taking bytes, the queue fills and frame_ready drops once four
// transactions are waiting, so no transaction is lost.
`timescale 1ns / 1ps
module http_host_request_filter_unit
    import hhf_pkg::*;
#(
    parameter int MAX_HOST_LEN    = HostLenDef,
    parameter int MAX_FRAME_BYTES = MaxFrameDef
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  frame_byte,
    input  logic        frame_last,
    input  logic        frame_valid,
    output logic        frame_ready,
    output logic        block_frame,
    output logic [2:0]  verdict,
    output logic [2:0]  method_found,
    output logic        result_valid,
    input  logic        result_ready,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    logic [255:0] pat_reg;
    logic [5:0]   hlen_reg;
    logic         f_valid, f_ready, b_valid, b_ready;
    token_t       f_tok, b_tok;
    result_t      res;

    // Pattern registers; the first pattern byte sits in the low bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg  <= '0;
            hlen_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HOST0: pat_reg[63:0]    <= cfg_data;
                CFG_HOST1: pat_reg[127:64]  <= cfg_data;
                CFG_HOST2: pat_reg[191:128] <= cfg_data;
                CFG_HOST3: pat_reg[255:192] <= cfg_data;
                CFG_HOST_LEN: hlen_reg      <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    hhf_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
        .clk(clk), .rst_n(rst_n), .frame_byte(frame_byte), .frame_last(frame_last),
        .frame_valid(frame_valid), .frame_ready(frame_ready),
        .tok_valid(f_valid), .tok(f_tok), .tok_ready(f_ready)
    );

    hhf_queue u_queue (
        .clk(clk), .rst_n(rst_n), .in_valid(f_valid), .in_ready(f_ready), .in_tok(f_tok),
        .out_valid(b_valid), .out_ready(b_ready), .out_tok(b_tok)
    );

    hhf_back #(.MAX_HOST_LEN(MAX_HOST_LEN)) u_back (
        .clk(clk), .rst_n(rst_n), .tok_valid(b_valid), .tok_ready(b_ready), .tok(b_tok),
        .pattern(pat_reg), .host_length(hlen_reg),
        .res_valid(result_valid), .res_ready(result_ready), .res(res)
    );

    assign block_frame  = res.block;
    assign verdict      = res.verdict;
    assign method_found = res.method;
endmodule

// ----- hw/rtl/hhf_front.sv -----
// Front stage: accepts frame bytes, tracks the frame position and classifies
// each byte. Depends on hhf_pkg.
`timescale 1ns / 1ps
module hhf_front
    import hhf_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MaxFrameDef
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] frame_byte,
    input  logic       frame_last,
    input  logic       frame_valid,
    output logic       frame_ready,
    output logic       tok_valid,
    output token_t     tok,
    input  logic       tok_ready
);
    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
    logic [PW-1:0] pos_reg, pos_next;
    logic          acc;

    assign frame_ready = tok_ready;
    assign tok_valid   = frame_valid;
    assign acc         = frame_valid && frame_ready;

    always_comb
    begin
        tok.data     = frame_byte;
        tok.last     = frame_last;
        tok.in_range = (pos_reg < PW'(MAX_FRAME_BYTES));
        tok.is_crlf  = (frame_byte == 8'h0D) || (frame_byte == 8'h0A);
        tok.is_sep   = (frame_byte == 8'h3A) || (frame_byte == 8'h20);
        pos_next = pos_reg;
        if (acc)
        begin
            if (frame_last)
                pos_next = '0;
            else if (tok.in_range)
                pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end
endmodule

// ----- hw/rtl/hhf_queue.sv -----
// Short queue between front and back stages.
// Depends on hhf_pkg.
`timescale 1ns / 1ps
module hhf_queue
    import hhf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  token_t in_tok,
    output logic   out_valid,
    input  logic   out_ready,
    output token_t out_tok
);
    localparam int AW = $clog2(QueueDepth);
    token_t        mem [QueueDepth];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          push, pop;

    assign in_ready  = (cnt_reg != (AW+1)'(QueueDepth));
    assign out_valid = (cnt_reg != '0);
    assign out_tok   = mem[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= in_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

// ----- hw/rtl/hhf_back.sv -----
// Back stage: runs the header and HTTP parse per byte and registers results.
// Depends on hhf_pkg.
`timescale 1ns / 1ps
module hhf_back
    import hhf_pkg::*;
#(
    parameter int MAX_HOST_LEN = HostLenDef
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tok_valid,
    output logic        tok_ready,
    input  token_t      tok,
    input  logic [255:0] pattern,
    input  logic [5:0]  host_length,
    output logic        res_valid,
    input  logic        res_ready,
    output result_t     res
);
    phase_t      ph_reg, ph_next;
    logic [15:0] bp_reg, bp_next;
    logic [5:0]  ihl_reg, ihl_next;
    logic [15:0] tot_reg, tot_next;
    logic [5:0]  thl_reg, thl_next;
    logic [15:0] rem_reg, rem_next;
    logic [5:0]  cand_reg, cand_next;
    logic [2:0]  tci_reg, tci_next;
    logic [5:0]  hci_reg, hci_next;
    logic [2:0]  ver_reg, ver_next;
    logic [2:0]  meth_reg, meth_next;
    logic        res_valid_reg;
    result_t     res_reg, res_next;
    logic        acc, emit;
    logic [5:0]  plen;
    logic [7:0]  b;
    logic [15:0] r, tcp_start;
    logic [5:0]  thl_eff;
    logic signed [17:0] seg;
    logic [5:0]  keep;
    logic        matched;
    logic [2:0]  match_id;
    logic [15:0] rem_dec;
    logic        pay;
    logic [7:0]  pbyte;
    phase_t      ph_fin;
    logic [2:0]  ver_fin;

    assign plen = (host_length > 6'(MAX_HOST_LEN)) ? 6'(MAX_HOST_LEN) : host_length;
    assign tok_ready = !res_valid_reg || res_ready;
    assign acc = tok_valid && tok_ready;
    assign b = tok.data;
    assign pbyte = pattern[hci_reg[4:0]*8 +: 8];
    assign res_valid = res_valid_reg;
    assign res = res_reg;

    always_comb
    begin
        ph_next = ph_reg; bp_next = bp_reg; ihl_next = ihl_reg; tot_next = tot_reg;
        thl_next = thl_reg; rem_next = rem_reg; cand_next = cand_reg; tci_next = tci_reg;
        hci_next = hci_reg; ver_next = ver_reg; meth_next = meth_reg;
        tcp_start = 16'd14 + 16'(ihl_reg);
        r = bp_reg - tcp_start;
        thl_eff = thl_reg;
        seg = '0; keep = '0; matched = 1'b0; match_id = '0; rem_dec = rem_reg;
        pay = 1'b0;
        if (tok.in_range && ph_reg != PH_DONE)
        begin
            unique case (ph_reg)
                PH_ETH:
                begin
                    if ((bp_reg == 16'd12 && b != 8'h08) || (bp_reg == 16'd13 && b != 8'h00))
                    begin
                        ver_next = V_NOT_IPV4; ph_next = PH_DONE;
                    end
                    else if (bp_reg == 16'd13)
                        ph_next = PH_IP;
                end
                PH_IP:
                begin
                    if (bp_reg == 16'd14)
                        ihl_next = (b[3:0] < 4'd5) ? 6'd20 : {b[3:0], 2'b00};
                    else if (bp_reg == 16'd16)
                        tot_next = {b, 8'h00};
                    else if (bp_reg == 16'd17)
                        tot_next = {tot_reg[15:8], b};
                    if (bp_reg == 16'd23 && b != 8'h06)
                    begin
                        ver_next = V_NOT_TCP; ph_next = PH_DONE;
                    end
                    else if (bp_reg + 16'd1 == 16'd14 + 16'(ihl_next))
                        ph_next = PH_TCP;
                end
                PH_TCP:
                begin
                    if (r == 16'd12)
                    begin
                        thl_eff = (b[7:4] < 4'd5) ? 6'd20 : {b[7:4], 2'b00};
                        thl_next = thl_eff;
                    end
                    if (r >= 16'd12 && r + 16'd1 == 16'(thl_eff))
                    begin
                        seg = 18'(tot_reg) - 18'(ihl_reg) - 18'(thl_eff);
                        if (seg <= 0)
                        begin
                            ver_next = V_NO_PAYLOAD; ph_next = PH_DONE;
                        end
                        else
                        begin
                            rem_next = seg[15:0]; ph_next = PH_L1_SKIP;
                        end
                    end
                end
                default:
                begin
                    pay = 1'b1;
                    unique case (ph_reg)
                        PH_L1_SKIP, PH_METHOD:
                        begin
                            if (ph_reg == PH_L1_SKIP && tok.is_crlf)
                                ;
                            else if (tok.is_crlf)
                            begin
                                ver_next = V_NO_METHOD; ph_next = PH_DONE;
                            end
                            else
                            begin
                                for (int i = 0; i < 6; i++)
                                    if ((ph_reg == PH_L1_SKIP || cand_reg[i]) &&
                                        ((ph_reg == PH_L1_SKIP ? 3'd0 : tci_reg) <
                                         method_len(3'(i))) &&
                                        b == method_char(3'(i),
                                            ph_reg == PH_L1_SKIP ? 3'd0 : tci_reg))
                                        keep[i] = 1'b1;
                                for (int i = 5; i >= 0; i--)
                                    if (keep[i] && (ph_reg == PH_L1_SKIP ? 3'd0 : tci_reg)
                                        + 3'd1 == method_len(3'(i)))
                                    begin
                                        matched = 1'b1; match_id = 3'(i);
                                    end
                                cand_next = keep;
                                if (matched)
                                begin
                                    meth_next = match_id; ph_next = PH_L1_REST;
                                end
                                else if (keep == '0)
                                begin
                                    ver_next = V_NO_METHOD; ph_next = PH_DONE;
                                end
                                else
                                begin
                                    ph_next = PH_METHOD;
                                    tci_next = (ph_reg == PH_L1_SKIP ? 3'd0 : tci_reg) + 3'd1;
                                end
                            end
                        end
                        PH_L1_REST:
                            if (tok.is_crlf) ph_next = PH_L2_SKIP;
                        PH_L2_SKIP:
                            if (!tok.is_crlf) ph_next = tok.is_sep ? PH_L2_SEP1 : PH_L2_TOK1;
                        PH_L2_SEP1:
                            if (tok.is_crlf)
                            begin
                                ver_next = V_MISMATCH; ph_next = PH_DONE;
                            end
                            else if (!tok.is_sep) ph_next = PH_L2_TOK1;
                        PH_L2_TOK1:
                            if (tok.is_crlf)
                            begin
                                ver_next = V_MISMATCH; ph_next = PH_DONE;
                            end
                            else if (tok.is_sep) ph_next = PH_L2_SEP2;
                        PH_L2_SEP2, PH_L2_TOK2:
                        begin
                            if (tok.is_crlf || (ph_reg == PH_L2_TOK2 && tok.is_sep))
                            begin
                                ver_next = V_MISMATCH; ph_next = PH_DONE;
                            end
                            else if (ph_reg == PH_L2_SEP2 && tok.is_sep)
                                ;
                            else if (ph_reg == PH_L2_SEP2 && plen == '0)
                            begin
                                ver_next = V_MATCH; ph_next = PH_DONE;
                            end
                            else
                            begin
                                ph_next = PH_L2_TOK2;
                                if (b != ((ph_reg == PH_L2_SEP2) ? pattern[7:0] : pbyte))
                                begin
                                    ver_next = V_MISMATCH; ph_next = PH_DONE;
                                end
                                else
                                begin
                                    hci_next = (ph_reg == PH_L2_SEP2) ? 6'd1 : hci_reg + 6'd1;
                                    if (hci_next >= plen)
                                    begin
                                        ver_next = V_MATCH; ph_next = PH_DONE;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                    if (rem_reg != '0)
                        rem_dec = rem_reg - 16'd1;
                    rem_next = rem_dec;
                end
            endcase
        end
        // End of payload data or the last frame byte closes any open parse.
        ph_fin = ph_next;
        ver_fin = ver_next;
        if ((pay && rem_dec == '0) || tok.last)
        begin
            if (tok.last && (ph_next == PH_ETH || ph_next == PH_IP || ph_next == PH_TCP))
                ver_fin = V_TRUNC;
            else if (ph_next == PH_L1_SKIP || ph_next == PH_METHOD)
                ver_fin = V_NO_METHOD;
            else if (ph_next == PH_L1_REST || ph_next == PH_L2_SKIP)
                ver_fin = V_NO_HOST;
            else if (ph_next >= PH_L2_SEP1 && ph_next <= PH_L2_TOK2)
                ver_fin = V_MISMATCH;
            if (ph_next != PH_DONE && !(tok.last && ph_next <= PH_TCP) ||
                tok.last && ph_next <= PH_TCP)
                ph_fin = PH_DONE;
        end
        ph_next = ph_fin;
        ver_next = ver_fin;
        if (tok.in_range)
            bp_next = bp_reg + 16'd1;
        res_next.block = (ver_next == V_MATCH);
        res_next.verdict = ver_next;
        res_next.method = meth_next;
        emit = acc && tok.last;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_ETH; bp_reg <= '0; ihl_reg <= '0; tot_reg <= '0; thl_reg <= '0;
            rem_reg <= '0; cand_reg <= '1; tci_reg <= '0; hci_reg <= '0;
            ver_reg <= V_TRUNC; meth_reg <= METHOD_NONE; res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && res_ready)
                res_valid_reg <= 1'b0;
            if (emit)
                res_valid_reg <= 1'b1;
            if (acc)
            begin
                if (tok.last)
                begin
                    ph_reg <= PH_ETH; bp_reg <= '0; ihl_reg <= '0; tot_reg <= '0;
                    thl_reg <= '0; rem_reg <= '0; cand_reg <= '1; tci_reg <= '0;
                    hci_reg <= '0; ver_reg <= V_TRUNC; meth_reg <= METHOD_NONE;
                end
                else
                begin
                    ph_reg <= ph_next; bp_reg <= bp_next; ihl_reg <= ihl_next;
                    tot_reg <= tot_next; thl_reg <= thl_next; rem_reg <= rem_next;
                    cand_reg <= cand_next; tci_reg <= tci_next; hci_reg <= hci_next;
                    ver_reg <= ver_next; meth_reg <= meth_next;
                end
            end
        end
    end
endmodule

// ----- hw/rtl/hhf_checker.sv -----
// Port-level checker for the filter top level, bound to it below.
// Depends on hhf_pkg and the defines header.
`timescale 1ns / 1ps
`include "http_host_request_filter_unit_defines.svh"
module hhf_checker
    import hhf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       frame_valid,
    input logic       frame_ready,
    input logic       result_valid,
    input logic       result_ready,
    input logic       block_frame,
    input logic [2:0] verdict,
    input logic [2:0] method_found
);
    `HHF_ASSERT_IMPL(a_block_iff_match, clk, rst_n, result_valid,
        block_frame == (verdict == V_MATCH), "block_frame disagrees with verdict")
    `HHF_ASSERT_IMPL(a_match_has_method, clk, rst_n, result_valid && verdict == V_MATCH,
        method_found != METHOD_NONE, "match without a method")
    `HHF_ASSERT_IMPL(a_method_range, clk, rst_n, result_valid,
        method_found != 3'd7, "method code out of range")
    `HHF_ASSERT_NEXT(a_result_holds, clk, rst_n, result_valid && !result_ready,
        result_valid && $stable(verdict), "result dropped while stalled")
    `HHF_ASSERT_NEXT(a_frame_holds, clk, rst_n, frame_valid && !frame_ready,
        frame_valid, "frame byte withdrawn before it was taken")
endmodule

bind http_host_request_filter_unit hhf_checker u_hhf_checker (
    .clk(clk), .rst_n(rst_n), .frame_valid(frame_valid), .frame_ready(frame_ready),
    .result_valid(result_valid), .result_ready(result_ready),
    .block_frame(block_frame), .verdict(verdict), .method_found(method_found)
);

// ----- sim/tb_http_host_request_filter_unit.sv -----
// Self-checking testbench for the HTTP host request filter top level.
// Depends on hhf_pkg and http_host_request_filter_unit; drives frames byte by byte.
`timescale 1ns / 1ps
module tb_http_host_request_filter_unit;
    import hhf_pkg::*;

    localparam int LAST_POS = 65535;

    logic        clk;
    logic        rst_n;
    logic [7:0]  frame_byte;
    logic        frame_last;
    logic        frame_valid;
    logic        frame_ready;
    logic        block_frame;
    logic [2:0]  verdict;
    logic [2:0]  method_found;
    logic        result_valid;
    logic        result_ready;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    http_host_request_filter_unit dut (
        .clk(clk), .rst_n(rst_n),
        .frame_byte(frame_byte), .frame_last(frame_last),
        .frame_valid(frame_valid), .frame_ready(frame_ready),
        .block_frame(block_frame), .verdict(verdict), .method_found(method_found),
        .result_valid(result_valid), .result_ready(result_ready),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Expected verdicts waiting for their result transaction.
    typedef struct packed {
        logic       block;
        logic [2:0] verdict;
        logic [2:0] method;
    } verdict_rec_t;

    verdict_rec_t verdict_queue[$];
    int unsigned  error_count;
    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;
    int unsigned  sent_count;

    // Shadow of the pattern registers.
    logic [63:0] pat_word[4];
    logic [5:0]  pat_len;

    // Shadow of the per-frame parse state.
    phase_t      ph;
    int unsigned pos;
    int unsigned ip_hdr;
    int unsigned ip_total;
    int unsigned tcp_hdr;
    int unsigned pay_left;
    logic [5:0]  cands;
    int unsigned tok_idx;
    int unsigned hidx;
    logic        host_ok;
    logic [2:0]  verd;
    logic [2:0]  meth;

    // Directed frames: bytes plus an optional hand-typed verdict (-1 = predictor only).
    typedef struct {
        string tag;
        int    want;
    } frame_row_t;

    task automatic report(input string what, input int got, input int exp);
        begin
            $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
            error_count++;
        end
    endtask

    function automatic void clear_frame();
        begin
            ph = PH_ETH; pos = 0; ip_hdr = 0; ip_total = 0; tcp_hdr = 0;
            pay_left = 0; cands = 6'h3f; tok_idx = 0; hidx = 0; host_ok = 1'b1;
            verd = V_TRUNC; meth = METHOD_NONE;
        end
    endfunction

    function automatic void settle(input verdict_t v);
        begin
            verd = v;
            ph = PH_DONE;
        end
    endfunction

    function automatic int unsigned eff_len();
        begin
            eff_len = (pat_len > 32) ? 32 : pat_len;
        end
    endfunction

    function automatic logic [7:0] pat_at(input int unsigned k);
        begin
            pat_at = pat_word[(k % 32) / 8][(k % 8) * 8 +: 8];
        end
    endfunction

    function automatic bit line_end(input logic [7:0] b);
        begin
            line_end = (b == 8'h0d) || (b == 8'h0a);
        end
    endfunction

    function automatic bit split_char(input logic [7:0] b);
        begin
            split_char = (b == 8'h3a) || (b == 8'h20);
        end
    endfunction

    function automatic string verb_text(input int m);
        begin
            case (m)
                0: verb_text = "GET";
                1: verb_text = "POST";
                2: verb_text = "HEAD";
                3: verb_text = "PUT";
                4: verb_text = "DELETE";
                default: verb_text = "OPTIONS";
            endcase
        end
    endfunction

    function automatic void host_step(input logic [7:0] b);
        begin
            if (b != pat_at(hidx))
                host_ok = 1'b0;
            hidx = (hidx + 1) % 64;
            if (!host_ok)
                settle(V_MISMATCH);
            else if (hidx >= eff_len())
                settle(V_MATCH);
        end
    endfunction

    function automatic void verb_step(input logic [7:0] b);
        logic [5:0] keep;
        string      s;
        begin
            keep = '0;
            if (line_end(b))
            begin
                settle(V_NO_METHOD);
                return;
            end
            for (int i = 0; i < 6; i++)
            begin
                s = verb_text(i);
                if (cands[i] && tok_idx < s.len() && b == s[tok_idx])
                    keep[i] = 1'b1;
            end
            cands = keep;
            for (int i = 0; i < 6; i++)
            begin
                s = verb_text(i);
                if (keep[i] && tok_idx + 1 == s.len())
                begin
                    meth = i[2:0];
                    ph = PH_L1_REST;
                    return;
                end
            end
            if (keep == 0)
            begin
                settle(V_NO_METHOD);
                return;
            end
            tok_idx = (tok_idx + 1) % 256;
        end
    endfunction

    function automatic void payload_end();
        begin
            if (ph == PH_L1_SKIP || ph == PH_METHOD)
                settle(V_NO_METHOD);
            else if (ph == PH_L1_REST || ph == PH_L2_SKIP)
                settle(V_NO_HOST);
            else if (ph >= PH_L2_SEP1 && ph <= PH_L2_TOK2)
                settle(V_MISMATCH);
        end
    endfunction

    function automatic void payload_step(input logic [7:0] b);
        begin
            case (ph)
                PH_L1_SKIP:
                    if (!line_end(b))
                    begin
                        ph = PH_METHOD;
                        tok_idx = 0;
                        verb_step(b);
                    end
                PH_METHOD: verb_step(b);
                PH_L1_REST: if (line_end(b)) ph = PH_L2_SKIP;
                PH_L2_SKIP:
                    if (!line_end(b))
                        ph = split_char(b) ? PH_L2_SEP1 : PH_L2_TOK1;
                PH_L2_SEP1:
                    if (line_end(b)) settle(V_MISMATCH);
                    else if (!split_char(b)) ph = PH_L2_TOK1;
                PH_L2_TOK1:
                    if (line_end(b)) settle(V_MISMATCH);
                    else if (split_char(b)) ph = PH_L2_SEP2;
                PH_L2_SEP2:
                    if (line_end(b))
                        settle(V_MISMATCH);
                    else if (!split_char(b))
                    begin
                        ph = PH_L2_TOK2;
                        hidx = 0;
                        host_ok = 1'b1;
                        if (eff_len() == 0)
                            settle(V_MATCH);
                        else
                            host_step(b);
                    end
                PH_L2_TOK2:
                    if (line_end(b) || split_char(b)) settle(V_MISMATCH);
                    else host_step(b);
                default: ;
            endcase
        end
    endfunction

    function automatic void header_step(input logic [7:0] b);
        int unsigned r;
        int          seg;
        begin
            if (ph == PH_ETH)
            begin
                if (pos == 12 && b != 8'h08)
                    settle(V_NOT_IPV4);
                else if (pos == 13)
                begin
                    if (b != 8'h00) settle(V_NOT_IPV4);
                    else ph = PH_IP;
                end
                return;
            end
            if (ph == PH_IP)
            begin
                if (pos == 14)
                    ip_hdr = (b[3:0] * 4 < 20) ? 20 : b[3:0] * 4;
                else if (pos == 16)
                    ip_total = b << 8;
                else if (pos == 17)
                    ip_total = ip_total | b;
                else if (pos == 23 && b != 8'h06)
                begin
                    settle(V_NOT_TCP);
                    return;
                end
                if (pos + 1 == 14 + ip_hdr)
                    ph = PH_TCP;
                return;
            end
            r = pos - (14 + ip_hdr);
            if (r == 12)
                tcp_hdr = (b[7:4] * 4 < 20) ? 20 : b[7:4] * 4;
            if (r >= 12 && r + 1 == tcp_hdr)
            begin
                seg = int'(ip_total) - int'(ip_hdr) - int'(tcp_hdr);
                if (seg <= 0)
                    settle(V_NO_PAYLOAD);
                else
                begin
                    pay_left = seg & 16'hffff;
                    ph = PH_L1_SKIP;
                end
            end
        end
    endfunction

    // Advances the shadow parser by one accepted byte and queues a verdict on the last one.
    function automatic void predict_byte(input logic [7:0] b, input logic last);
        verdict_rec_t rec;
        begin
            if (pos < LAST_POS && ph != PH_DONE)
            begin
                if (ph <= PH_TCP)
                    header_step(b);
                else
                begin
                    payload_step(b);
                    if (pay_left > 0) pay_left--;
                    if (pay_left == 0) payload_end();
                end
            end
            if (pos < LAST_POS)
                pos++;
            if (last)
            begin
                if (ph <= PH_TCP) settle(V_TRUNC);
                else payload_end();
                rec.block = (verd == V_MATCH);
                rec.verdict = verd;
                rec.method = meth;
                verdict_queue.push_back(rec);
                clear_frame();
            end
        end
    endfunction

    // Result side: compare each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        verdict_rec_t e;
        if (rst_n && result_valid && result_ready)
        begin
            if (verdict_queue.size() == 0)
                report("unexpected result", verdict, -1);
            else
            begin
                e = verdict_queue.pop_front();
                if (verdict !== e.verdict) report("verdict", verdict, e.verdict);
                if (block_frame !== e.block) report("block_frame", block_frame, e.block);
                if (method_found !== e.method) report("method_found", method_found, e.method);
            end
        end
    end

    // Receiver stalls at the phase's rate.
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Valid stays high between back-to-back bytes; it only drops for an idle gap.
    task automatic put_byte(input logic [7:0] b, input logic last);
        begin
            if ($urandom_range(99) < send_idle_pct)
            begin
                frame_valid <= 1'b0;
                @(posedge clk);
                while ($urandom_range(99) < send_idle_pct)
                    @(posedge clk);
            end
            frame_byte <= b;
            frame_last <= last;
            frame_valid <= 1'b1;
            @(posedge clk);
            while (!frame_ready)
                @(posedge clk);
            predict_byte(b, last);
            sent_count++;
        end
    endtask

    task automatic send_frame(input byte unsigned fr[$]);
        begin
            foreach (fr[i])
                put_byte(fr[i], i == fr.size() - 1);
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val;
            @(posedge clk);
            cfg_we <= 1'b0;
            if (idx == CFG_HOST_LEN) pat_len = val[5:0];
            else pat_word[idx[1:0]] = val;
            @(posedge clk);
        end
    endtask

    // Waits for every pending result, then lets the pipeline empty.
    task automatic drain();
        begin
            frame_valid <= 1'b0;
            while (verdict_queue.size() != 0)
                @(posedge clk);
            repeat (8) @(posedge clk);
        end
    endtask

    task automatic set_pattern(input string host, input int len);
        logic [63:0] w[4];
        begin
            w = '{default: '0};
            for (int i = 0; i < host.len() && i < 32; i++)
                w[i / 8][(i % 8) * 8 +: 8] = host[i];
            for (int i = 0; i < 4; i++)
                write_reg(cfg_idx_t'(i), w[i]);
            write_reg(CFG_HOST_LEN, 64'(len));
        end
    endtask

    // Builds Ethernet + IPv4 + TCP headers in front of a payload.
    function automatic void build_frame(output byte unsigned fr[$], input string payload,
                                        input int ihl, input int doff, input int tot_adj,
                                        input byte unsigned proto, input bit bad_type);
        int ih;
        int th;
        int tot;
        begin
            fr = {};
            ih = (ihl < 5 ? 5 : ihl) * 4;
            th = (doff < 5 ? 5 : doff) * 4;
            tot = ih + th + payload.len() + tot_adj;
            if (tot < 0) tot = 0;
            for (int i = 0; i < 12; i++) fr.push_back($urandom_range(255));
            fr.push_back(bad_type ? 8'h86 : 8'h08);
            fr.push_back(8'h00);
            for (int i = 0; i < ih; i++)
            begin
                case (i)
                    0: fr.push_back({4'h4, ihl[3:0]});
                    2: fr.push_back(tot[15:8]);
                    3: fr.push_back(tot[7:0]);
                    9: fr.push_back(proto);
                    default: fr.push_back($urandom_range(255));
                endcase
            end
            for (int i = 0; i < th; i++)
                fr.push_back(i == 12 ? {doff[3:0], 4'($urandom_range(15))}
                                     : 8'($urandom_range(255)));
            for (int i = 0; i < payload.len(); i++)
                fr.push_back(payload[i]);
        end
    endfunction

    function automatic string rand_text(input int n);
        string s;
        byte   pool[] = '{"a", "b", ".", "x", "-", "1", " ", ":", "\r", "\n", 8'h00, 8'hff};
        begin
            s = "";
            for (int i = 0; i < n; i++)
                s = {s, string'(($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                : pool[$urandom_range(pool.size() - 1)])};
            rand_text = s;
        end
    endfunction

    // A mostly well-formed request with random hosts near the current pattern.
    function automatic string rand_request(input string host);
        string s;
        string h;
        begin
            h = host.substr(0, $urandom_range(host.len()) - 1);
            if ($urandom_range(1)) h = {h, rand_text($urandom_range(4))};
            s = ($urandom_range(3) == 0) ? "\r\n" : "";
            s = {s, verb_text($urandom_range(5)), " /", rand_text($urandom_range(4)),
                 " HTTP/1.1\r\n"};
            if ($urandom_range(4) == 0) s = {s, "\n"};
            s = {s, ($urandom_range(4) == 0) ? " " : "", "Host", ($urandom_range(1) ? ": " : ":"),
                 h, "\r\n"};
            if ($urandom_range(7) == 0) s = s.substr(0, $urandom_range(s.len() - 1));
            rand_request = s;
        end
    endfunction

    frame_row_t  rows[$];
    string       hosts[4];

    initial
    begin
        byte unsigned fr[$];
        string        pat;
        string        pl;

        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sent_count = 0;
        frame_byte = '0;
        frame_last = 1'b0;
        frame_valid = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_HOST0;
        cfg_data = '0;
        pat_word = '{default: '0};
        pat_len = '0;
        clear_frame();
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: one short table of payloads under a fixed pattern.
        pat = "host.example";
        set_pattern(pat, pat.len());
        rows = '{
            '{"GET / HTTP/1.1\r\nHost: host.example.org\r\n", V_MATCH},
            '{"POST /x\r\nHost: other\r\n", V_MISMATCH},
            '{"HEAD /\r\nHost: host.ex\r\n", V_MISMATCH},
            '{"PUT /\r\nHost:host.example\r\n", V_MATCH},
            '{"DELETE /\r\n\r\nX host.example\r\n", V_MATCH},
            '{"OPTIONS *\r\nHost: host.example\r\n", V_MATCH},
            '{"\r\n\nGET /\r\nHost: host.example\r\n", V_MATCH},
            '{"FETCH /\r\nHost: host.example\r\n", V_NO_METHOD},
            '{"GE\r\n", V_NO_METHOD},
            '{"GET /index\r\n", V_NO_HOST},
            '{"GET /\r\nHost\r\n", V_MISMATCH},
            '{"GET /\r\nHost: \r\n", V_MISMATCH},
            '{"GET /\r\nHost: host\000example\r\n", V_MISMATCH}
        };
        foreach (rows[i])
        begin
            build_frame(fr, rows[i].tag, 5, 5, 0, 8'h06, 1'b0);
            send_frame(fr);
            if (rows[i].want >= 0 && verdict_queue[$].verdict != 3'(rows[i].want))
                report("table verdict", verdict_queue[$].verdict, rows[i].want);
            drain();
        end
        // Header corner cases: wrong type, wrong protocol, short headers,
        // empty and negative segment, truncation, wide headers.
        build_frame(fr, "GET", 5, 5, 0, 8'h06, 1'b1); send_frame(fr);
        build_frame(fr, "GET", 5, 5, 0, 8'h11, 1'b0); send_frame(fr);
        build_frame(fr, "GET /\r\nH host.example\r\n", 2, 0, 0, 8'h06, 1'b0); send_frame(fr);
        build_frame(fr, "", 5, 5, 0, 8'h06, 1'b0); send_frame(fr);
        build_frame(fr, "GET /\r\nH host.example", 5, 5, -30, 8'h06, 1'b0); send_frame(fr);
        build_frame(fr, "GET /\r\nH host.example\r\n", 15, 15, 0, 8'h06, 1'b0); send_frame(fr);
        build_frame(fr, "", 5, 5, 0, 8'h06, 1'b0);
        fr = fr[0:29];
        send_frame(fr);
        put_byte(8'hff, 1'b1);
        // Payload longer than the segment: trailing bytes are ignored.
        build_frame(fr, "GET /\r\nH host.example\r\n", 5, 5, -22, 8'h06, 1'b0); send_frame(fr);
        drain();

        // Empty pattern and full 32-byte pattern extremes, with an oversized length.
        set_pattern("", 0);
        build_frame(fr, "GET /\r\nHost: z\r\n", 5, 5, 0, 8'h06, 1'b0); send_frame(fr);
        drain();
        write_reg(CFG_HOST0, 64'hffff_ffff_ffff_ffff);
        write_reg(CFG_HOST1, 64'hffff_ffff_ffff_ffff);
        write_reg(CFG_HOST2, 64'hffff_ffff_ffff_ffff);
        write_reg(CFG_HOST3, 64'hffff_ffff_ffff_ffff);
        write_reg(CFG_HOST_LEN, 64'd63);
        pl = "GET /\r\nH ";
        for (int i = 0; i < 33; i++) pl = {pl, string'(8'hff)};
        build_frame(fr, pl, 5, 5, 0, 8'h06, 1'b0); send_frame(fr);
        drain();

        // Random part over several pattern settings and idling phases.
        hosts = '{"w.example.net", "a", "abcdefghijklmnopqrstuvwxyz012345", "k8:x"};
        for (int phz = 0; phz < 4; phz++)
        begin
            case (phz)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 50; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 50; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            pat = hosts[phz];
            set_pattern(pat, (phz == 3) ? 32 : pat.len());
            if (phz == 3) pat = pat.substr(0, 3);
            while (sent_count < 1850 + 1850 * (phz + 1) / 8)
            begin
                case ($urandom_range(9))
                    0: begin
                        fr = {};
                        for (int i = $urandom_range(40); i >= 0; i--)
                            fr.push_back($urandom_range(255));
                    end
                    1: build_frame(fr, rand_text($urandom_range(30)), $urandom_range(15),
                                   $urandom_range(15), int'($urandom_range(60)) - 30,
                                   $urandom_range(1) ? 8'h06 : 8'($urandom_range(255)),
                                   $urandom_range(7) == 0);
                    default: build_frame(fr, rand_request(pat), $urandom_range(4, 7),
                                         $urandom_range(4, 7),
                                         ($urandom_range(5) == 0)
                                             ? int'($urandom_range(20)) - 10 : 0,
                                         8'h06, 1'b0);
                endcase
                if (fr.size() > 90 && $urandom_range(3) != 0) fr = fr[0:89];
                send_frame(fr);
            end
            drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        if (error_count == 0)
            $display("tb_http_host_request_filter_unit: done, clean");
        else
            $display("tb_http_host_request_filter_unit: done, errors");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #100ms;
        $display("tb_http_host_request_filter_unit: done, errors");
        $finish;
    end
endmodule
